// File: hdl/pid_velocity_controller_assert.svh
// assertion helpers used by the checker file
`ifndef PID_VELOCITY_CONTROLLER_ASSERT_SVH
`define PID_VELOCITY_CONTROLLER_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define PVC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("check failed");

// clocked check that also holds during reset
`define PVC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("check failed during reset");

`endif

// File: hdl/pidvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidvc_pkg;

  // payload and register widths
  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned DiffW  = 18;
  localparam int unsigned SumW   = 32;
  localparam int unsigned MulAW  = 34;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned AccW   = 44;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_TICK_PERIOD = 3'd3,
    REG_TICK_RATE   = 3'd4,
    REG_OUT_MAX     = 3'd5,
    REG_OUT_MIN     = 3'd6
  } reg_idx_e;

  // register reset values
  localparam logic [DataW-1:0]        PropGainRst   = 16'd230;
  localparam logic [DataW-1:0]        IntegGainRst  = 16'd1792;
  localparam logic [DataW-1:0]        DerivGainRst  = 16'd0;
  localparam logic [DataW-1:0]        TickPeriodRst = 16'd655;
  localparam logic [DataW-1:0]        TickRateRst   = 16'd100;
  localparam logic signed [DataW-1:0] OutMaxRst     = 16'sh1000;
  localparam logic signed [DataW-1:0] OutMinRst     = 16'shF000;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_MUL_DT  = 7'b0000010,
    ST_ACC_SUM = 7'b0000100,
    ST_ACC_P   = 7'b0001000,
    ST_ACC_I   = 7'b0010000,
    ST_MUL_D   = 7'b0100000,
    ST_ACC_D   = 7'b1000000
  } state_e;

  // limit a wide value to [lo, hi]; crossed limits end at lo
  function automatic logic signed [DataW-1:0] clamp_lim(
    input logic signed [AccW-1:0]  v,
    input logic signed [DataW-1:0] hi,
    input logic signed [DataW-1:0] lo
  );
    logic signed [AccW-1:0] r;
    r = v;
    if (r > AccW'(hi)) r = AccW'(hi);
    if (r < AccW'(lo)) r = AccW'(lo);
    return r[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/pid_velocity_controller.sv
// pid velocity controller with output clamp
//
// input channel: in_valid_i / in_ready_o carry one control tick
// (target_velocity_i, measured_velocity_i, signed Q4.12). output channel:
// out_valid_o / out_ready_i carry the clamped drive_o (signed Q4.12).
// gains, period, rate and limits are written through cfg_we_i, cfg_index_i
// and cfg_data_i, by the user while no tick is in flight; the block never checks.
//
// one shared 34x17 multiplier runs under a small sequencer: a nonzero
// tick steps through ST_MUL_DT, ST_ACC_SUM, ST_ACC_P, ST_ACC_I, ST_MUL_D
// and ST_ACC_D (integral product, saturate with proportional product,
// integral gain product, two derivative products, sum) to the result
// register; a zero target sets the zero flag, then drives 0. in_ready_o is
// high only in idle with no zero tick pending: a new tick waits for the last.
//
// the result register holds a drive until taken; a stalled receiver holds
// the finished tick in the sequencer and then blocks new ticks.
// reset loads the default gains and limits and clears the integral, the
// stored error and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module pid_velocity_controller import pidvc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [DataW-1:0]    target_velocity_i,
  input  wire logic signed [DataW-1:0]    measured_velocity_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [DataW-1:0]         drive_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [DataW-1:0]           cfg_data_i
);

  // configuration registers
  logic [DataW-1:0]        prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [DataW-1:0]        tick_period_q, tick_rate_q;
  logic signed [DataW-1:0] out_max_q, out_min_q;

  // sequencer and datapath state
  state_e                  state_q, state_d;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic signed [ErrW-1:0]  last_error_q, last_error_d;
  logic signed [SumW-1:0]  error_sum_q, error_sum_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    zero_q, zero_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] drive_q, drive_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [DataW-1:0] tgt_clamped;
  logic signed [DiffW-1:0] err_diff;
  logic signed [SumW:0]    sum_wide;
  logic                    in_fire, out_free;

  assign in_ready_o  = (state_q == ST_IDLE) && !zero_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PropGainRst;
      integ_gain_q  <= IntegGainRst;
      deriv_gain_q  <= DerivGainRst;
      tick_period_q <= TickPeriodRst;
      tick_rate_q   <= TickRateRst;
      out_max_q     <= OutMaxRst;
      out_min_q     <= OutMinRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
        REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
        REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i;
        REG_TICK_PERIOD: tick_period_q <= cfg_data_i;
        REG_TICK_RATE:   tick_rate_q   <= cfg_data_i;
        REG_OUT_MAX:     out_max_q     <= cfg_data_i;
        REG_OUT_MIN:     out_min_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input clamp and error difference
  assign tgt_clamped = clamp_lim(AccW'(target_velocity_i), out_max_q, out_min_q);
  assign err_diff    = DiffW'(err_q) - DiffW'(last_error_q);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_DT: begin
        mul_a = MulAW'(err_q);
        mul_b = {1'b0, tick_period_q};
      end
      ST_ACC_SUM: begin
        mul_a = MulAW'(err_q);
        mul_b = {1'b0, prop_gain_q};
      end
      ST_ACC_P: begin
        mul_a = MulAW'(error_sum_q);
        mul_b = {1'b0, integ_gain_q};
      end
      ST_ACC_I: begin
        mul_a = MulAW'(err_diff);
        mul_b = {1'b0, tick_rate_q};
      end
      ST_MUL_D: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = {1'b0, deriv_gain_q};
      end
      default: ;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign sum_wide = (SumW+1)'(error_sum_q) + (SumW+1)'(prod_q >>> 12);

  // sequencer
  always_comb begin
    state_d      = state_q;
    err_d        = err_q;
    last_error_d = last_error_q;
    error_sum_d  = error_sum_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    zero_d       = zero_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    drive_d      = drive_q;
    case (state_q)
      ST_IDLE: begin
        if (zero_q) begin
          // zero target: drive 0, state untouched
          if (out_free) begin
            out_valid_d = 1'b1;
            drive_d     = '0;
            zero_d      = 1'b0;
          end
        end else if (in_fire) begin
          err_d = ErrW'(tgt_clamped) - ErrW'(measured_velocity_i);
          if (tgt_clamped == '0) begin
            zero_d = 1'b1;
          end else begin
            state_d = ST_MUL_DT;
          end
        end
      end
      ST_MUL_DT: begin
        prod_d  = mul_p;
        state_d = ST_ACC_SUM;
      end
      ST_ACC_SUM: begin
        // saturate the integral to 32 bits
        if (sum_wide[SumW] != sum_wide[SumW-1]) begin
          error_sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                       : {1'b0, {(SumW-1){1'b1}}};
        end else begin
          error_sum_d = sum_wide[SumW-1:0];
        end
        prod_d  = mul_p;
        state_d = ST_ACC_P;
      end
      ST_ACC_P: begin
        acc_d   = AccW'(prod_q >>> 8);
        prod_d  = mul_p;
        state_d = ST_ACC_I;
      end
      ST_ACC_I: begin
        acc_d   = acc_q + AccW'(prod_q >>> 12);
        prod_d  = mul_p;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        prod_d  = mul_p;
        state_d = ST_ACC_D;
      end
      ST_ACC_D: begin
        // final sum, clamp and hand over once the result slot is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          drive_d      = clamp_lim(acc_q + AccW'(prod_q >>> 8), out_max_q, out_min_q);
          last_error_d = err_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      zero_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else begin
      state_q      <= state_d;
      zero_q       <= zero_d;
      out_valid_q  <= out_valid_d;
      error_sum_q  <= error_sum_d;
      last_error_q <= last_error_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    drive_q <= drive_d;
  end

endmodule

`default_nettype wire

// File: hdl/pidvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pid_velocity_controller_assert.svh"

module pidvc_checker import pidvc_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [DataW-1:0] drive_o
);

  // reset leaves no result pending
  `PVC_ASSERT_RST(a_rst_no_out, !rst_ni |=> !out_valid_o)

  // one tick at a time: a transaction closes the input until it is done
  `PVC_ASSERT(a_in_one_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // a waiting drive holds until taken
  `PVC_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(drive_o)))

  // a result disappears only through a transaction
  `PVC_ASSERT(a_out_drop, $fell(out_valid_o) |-> $past(out_ready_i))

endmodule

bind pid_velocity_controller pidvc_checker u_pidvc_checker (.*);

`default_nettype wire
